/* design/booth_radix2_multiplier_unit_macros.svh */
// Assertion helpers for the Booth multiplier RTL.
// Every check is sampled on the rising edge of aclk.
`ifndef BOOTH_RADIX2_MULTIPLIER_UNIT_MACROS_SVH
`define BOOTH_RADIX2_MULTIPLIER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check that is masked while aresetn is low
`define BMU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check that also runs during reset
`define BMU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define BMU_ASSERT(label, prop, msg)
`define BMU_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

/* design/bmu_pkg.sv */
package bmu_pkg;

    // Operand width of the Booth datapath
    localparam int WIDTH = 16;
    // Widths of the stream fields
    localparam int IN_W  = 16;
    localparam int OUT_W = 32;
    localparam int S_TDATA_W = ((2 * IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((OUT_W + 7) / 8) * 8;

    // Booth steps per pipeline stage, and the resulting stage count
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_STAGES = (WIDTH + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

    // Recoding of {Q0, Q(-1)}
    localparam logic [1:0] BOOTH_SUB = 2'b10;
    localparam logic [1:0] BOOTH_ADD = 2'b01;

    // Partial state of one item between steps
    typedef struct packed {
        logic signed [WIDTH-1:0] m;     // multiplicand
        logic signed [WIDTH:0]   acc;   // accumulator with guard bit
        logic [WIDTH-1:0]        q;     // multiplier, shifted right each step
        logic                    qm1;   // Q(-1)
    } stage_t;

    // One radix-2 Booth step: add/subtract, then arithmetic shift of A:Q:Q(-1)
    function automatic stage_t booth_step(stage_t s);
        stage_t r;
        logic signed [WIDTH:0] m_ext;
        logic signed [WIDTH:0] sum;
        m_ext = (WIDTH + 1)'(s.m);
        case ({s.q[0], s.qm1})
            BOOTH_SUB: sum = s.acc - m_ext;
            BOOTH_ADD: sum = s.acc + m_ext;
            default:   sum = s.acc;
        endcase
        r.m   = s.m;
        r.qm1 = s.q[0];
        r.q   = {sum[0], s.q[WIDTH-1:1]};
        r.acc = {sum[WIDTH], sum[WIDTH:1]};
        return r;
    endfunction

endpackage

/* design/booth_radix2_multiplier_unit.sv */
// Radix-2 Booth signed multiplier, fully pipelined. Each item carries a signed
// multiplicand and multiplier and yields their exact signed product (low 32 bits).
// The WIDTH Booth steps are spread over NUM_STAGES register stages of
// STEPS_PER_STAGE steps each (4 stages of 4 steps at WIDTH = 16), and one item
// can enter every cycle while the output is not stalled. The last stage is the
// output register; with m_tready low the pipeline fills bubbles first and only
// then holds s_tready low.
`include "booth_radix2_multiplier_unit_macros.svh"

module booth_radix2_multiplier_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [15:0] multiplicand, [31:16] multiplier
    input  logic [bmu_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [31:0] product
    output logic [bmu_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int W  = bmu_pkg::WIDTH;
    localparam int NS = bmu_pkg::NUM_STAGES;
    localparam int S  = bmu_pkg::STEPS_PER_STAGE;

    logic signed [bmu_pkg::IN_W-1:0] mcand;
    logic signed [bmu_pkg::IN_W-1:0] mplier;
    bmu_pkg::stage_t                 init_state;

    bmu_pkg::stage_t stage_src  [NS];
    bmu_pkg::stage_t stage_next [NS];
    bmu_pkg::stage_t stage_reg  [NS];
    logic [NS-1:0]   src_vld;
    logic [NS-1:0]   vld_reg;
    logic [NS-1:0]   rdy;

    logic signed [2*W:0] full_prod;

    // Unpack operands and build the starting state
    assign mcand  = s_tdata[bmu_pkg::IN_W-1:0];
    assign mplier = s_tdata[2*bmu_pkg::IN_W-1:bmu_pkg::IN_W];

    always_comb begin
        init_state.m   = W'(mcand);
        init_state.acc = '0;
        init_state.q   = W'(mplier);
        init_state.qm1 = 1'b0;
    end

    for (genvar k = 0; k < NS; k++) begin : g_stage
        // Stage input
        if (k == 0) begin : g_first
            assign stage_src[k] = init_state;
            assign src_vld[k]   = s_tvalid;
        end else begin : g_rest
            assign stage_src[k] = stage_reg[k-1];
            assign src_vld[k]   = vld_reg[k-1];
        end

        // Stage advances when empty or when the downstream stage moves
        if (k == NS - 1) begin : g_last_rdy
            assign rdy[k] = !vld_reg[k] || m_tready;
        end else begin : g_mid_rdy
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end

        // Booth steps of this stage
        always_comb begin : p_steps
            bmu_pkg::stage_t st;
            st = stage_src[k];
            for (int j = 0; j < S; j++) begin
                if (k * S + j < W) begin
                    st = bmu_pkg::booth_step(st);
                end
            end
            stage_next[k] = st;
        end

        // Valid bit
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (rdy[k]) begin
                vld_reg[k] <= src_vld[k];
            end
        end

        // Payload, no reset
        always_ff @(posedge aclk) begin
            if (rdy[k] && src_vld[k]) begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign s_tready = rdy[0];

    // Product is A:Q of the last stage
    assign full_prod = {stage_reg[NS-1].acc, stage_reg[NS-1].q};
    assign m_tvalid  = vld_reg[NS-1];
    assign m_tdata   = bmu_pkg::M_TDATA_W'(bmu_pkg::OUT_W'(full_prod));

    // An accepted item always lands in the first stage
    `BMU_ASSERT(a_accept_fills, s_tvalid && s_tready |=> vld_reg[0], "accepted item not captured")
    // An empty output stage never backpressures the input
    `BMU_ASSERT(a_empty_ready, !m_tvalid |-> s_tready, "input stalled with empty output stage")
    // A stalled first stage keeps its item unchanged
    `BMU_ASSERT(a_hold_first, vld_reg[0] && !rdy[0] |=> vld_reg[0] && $stable(stage_reg[0]), "first stage lost its item while stalled")
    // Nothing is offered right after reset
    `BMU_ASSERT_ALWAYS(a_reset_clear, !aresetn |=> !m_tvalid, "output valid after reset")

endmodule
